FILE: hw/rtl/two_image_seam_feather_blend_defines.svh
// ----------------------------------------------------------------------------
// Seam feather blend assertion macros
// Shared concurrent assertion forms for the blend checker.
// ----------------------------------------------------------------------------
`ifndef TWO_IMAGE_SEAM_FEATHER_BLEND_DEFINES_SVH
`define TWO_IMAGE_SEAM_FEATHER_BLEND_DEFINES_SVH

// assertion that is muted while reset is held
`define TISFB_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("tisfb assertion failed");

// assertion that is checked also during reset
`define TISFB_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("tisfb assertion failed");

`endif

FILE: hw/rtl/tisfb_pkg.sv
// ----------------------------------------------------------------------------
// Seam feather blend package
// Types and constants shared by the blend pipeline.
// ----------------------------------------------------------------------------
package tisfb_pkg;

  localparam logic [7:0] SEAM_WIDTH_RST = 8'd32;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned PIPE_DEPTH = DIV_STEPS + 2;

  typedef enum logic [1:0] {
    SRC_RAMP  = 2'd0,
    SRC_RIGHT = 2'd1,
    SRC_LEFT  = 2'd2
  } src_t;

  // one divide step state for the three channels
  typedef struct packed {
    logic [7:0]      w;
    src_t            src;
    logic [2:0][7:0] part;
    logic [2:0][7:0] nq;
  } div_item_t;

endpackage

FILE: hw/rtl/tisfb_div_step.sv
// ----------------------------------------------------------------------------
// Seam feather blend divide step
// One registered restoring-division step: one quotient bit per channel.
// ----------------------------------------------------------------------------
module tisfb_div_step (
  input  logic                 clk,
  input  logic                 load,
  input  tisfb_pkg::div_item_t item_in,
  output tisfb_pkg::div_item_t item_r
);

  tisfb_pkg::div_item_t item_nxt;

  always_comb begin
    logic [8:0] trial;
    logic [7:0] diff;
    logic       ge;
    item_nxt = item_in;
    for (int c = 0; c < 3; c++) begin
      trial = {item_in.part[c], item_in.nq[c][7]};
      diff  = trial[7:0] - item_in.w;
      ge    = (trial >= {1'b0, item_in.w});
      item_nxt.part[c] = ge ? diff : trial[7:0];
      item_nxt.nq[c]   = {item_in.nq[c][6:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hw/rtl/two_image_seam_feather_blend.sv
// ----------------------------------------------------------------------------
// Two-image seam feather blend
// Ramp blend of left and right RGB pixels across a seam band, with
// black-pixel pass-through.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one blended pixel per clock when the
// output is not stalled. The pipeline holds the restoring divide by the seam
// width, one quotient bit per pipeline stage over eight stages, after a stage
// of weight selection and a stage of multiply-add. Stages hold their data on
// backpressure and bubbles are squeezed out. seam_width is taken at any
// time but must only change while no pixel is in flight.
module two_image_seam_feather_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // seam_width
  input  logic        in_tvalid,
  output logic        in_tready,
  // seam_column, left_red, left_green, left_blue, right_red, right_green,
  // right_blue
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // out_red, out_green, out_blue
  output logic [1:0]  out_tuser     // weight_source
);

  localparam int unsigned DEPTH = tisfb_pkg::PIPE_DEPTH;
  localparam int unsigned STEPS = tisfb_pkg::DIV_STEPS;

  logic [7:0]       seam_width_r;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] rdy;

  // stage 1
  logic [7:0]       s1_w_r, s1_wl_r, s1_wr_r;
  logic [2:0][7:0]  s1_left_r, s1_right_r;
  tisfb_pkg::src_t  s1_src_r;
  logic [7:0]       s1_w_nxt, s1_wl_nxt, s1_wr_nxt, col_clamp;
  logic [2:0][7:0]  in_left, in_right;
  tisfb_pkg::src_t  s1_src_nxt;

  tisfb_pkg::div_item_t div_q [STEPS+1];
  tisfb_pkg::div_item_t s2_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seam_width_r <= tisfb_pkg::SEAM_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      seam_width_r <= cfg_data;
    end
  end

  // handshake chain
  always_comb begin
    rdy[DEPTH-1] = !vld_r[DEPTH-1] || out_tready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: clamp and weight select
  always_comb begin
    in_left  = {in_tdata[31:24], in_tdata[23:16], in_tdata[15:8]};
    in_right = {in_tdata[55:48], in_tdata[47:40], in_tdata[39:32]};
    s1_w_nxt = (seam_width_r == 8'd0) ? 8'd1 : seam_width_r;
    col_clamp = (in_tdata[7:0] >= s1_w_nxt) ? s1_w_nxt - 8'd1 : in_tdata[7:0];
    if (in_left == '0) begin
      s1_src_nxt = tisfb_pkg::SRC_RIGHT;
      s1_wl_nxt  = 8'd0;
      s1_wr_nxt  = s1_w_nxt;
    end else if (in_right == '0) begin
      s1_src_nxt = tisfb_pkg::SRC_LEFT;
      s1_wl_nxt  = s1_w_nxt;
      s1_wr_nxt  = 8'd0;
    end else begin
      s1_src_nxt = tisfb_pkg::SRC_RAMP;
      s1_wl_nxt  = s1_w_nxt - col_clamp;
      s1_wr_nxt  = col_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_w_r     <= s1_w_nxt;
      s1_wl_r    <= s1_wl_nxt;
      s1_wr_r    <= s1_wr_nxt;
      s1_left_r  <= in_left;
      s1_right_r <= in_right;
      s1_src_r   <= s1_src_nxt;
    end
  end

  // stage 2: weighted sum, seeds the divider; the sum never exceeds 255 * w
  always_comb begin
    logic [15:0] acc;
    s2_nxt.w   = s1_w_r;
    s2_nxt.src = s1_src_r;
    for (int c = 0; c < 3; c++) begin
      acc = 16'(s1_left_r[c]) * 16'(s1_wl_r) + 16'(s1_right_r[c]) * 16'(s1_wr_r);
      s2_nxt.part[c] = acc[15:8];
      s2_nxt.nq[c]   = acc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      div_q[0] <= s2_nxt;
    end
  end

  // divide stages
  for (genvar g = 0; g < STEPS; g++) begin : g_div
    tisfb_div_step u_step (
      .clk     (clk),
      .load    (rdy[g+2]),
      .item_in (div_q[g]),
      .item_r  (div_q[g+1])
    );
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {div_q[STEPS].nq[2], div_q[STEPS].nq[1], div_q[STEPS].nq[0]};
  assign out_tuser  = div_q[STEPS].src;

endmodule

FILE: hw/rtl/tisfb_checker.sv
// ----------------------------------------------------------------------------
// Seam feather blend checker
// Port-level assertions for the blend block, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_image_seam_feather_blend_defines.svh"

module tisfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `TISFB_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `TISFB_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid)
  `TISFB_ASSERT(a_flow_through, clk, rst_n, out_tready |-> in_tready)
  `TISFB_ASSERT(a_cfg_open, clk, rst_n, cfg_valid |-> cfg_ready)

endmodule

bind two_image_seam_feather_blend tisfb_checker u_tisfb_checker (.*);

FILE: tb/tb_two_image_seam_feather_blend.sv
// ----------------------------------------------------------------------------
// Seam feather blend testbench
// Streams pixel pairs through the blend with random gaps on both sides,
// rewrites the seam width between bursts and checks every blended pixel
// against a local ramp and black pass-through prediction.
// ----------------------------------------------------------------------------
module tb_two_image_seam_feather_blend;

  // packed MSB first, so seam_column lands in the low byte of in_tdata
  typedef struct packed {
    logic [7:0] right_blue;
    logic [7:0] right_green;
    logic [7:0] right_red;
    logic [7:0] left_blue;
    logic [7:0] left_green;
    logic [7:0] left_red;
    logic [7:0] seam_column;
  } pixel_t;

  typedef struct packed {
    tisfb_pkg::src_t src;
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
  } blend_t;

  typedef struct {
    logic       is_cfg;
    logic [7:0] width;
    pixel_t     pix;
    logic       typed;
    blend_t     want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  two_image_seam_feather_blend uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  blend_t      blend_q[$];
  logic [7:0]  seam_width_mdl = tisfb_pkg::SEAM_WIDTH_RST;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 51;
  logic        cur_typed;
  blend_t      cur_want;
  blend_t      got;
  blend_t      want;
  row_t        dir_tab[$];

  function automatic logic [7:0] ramp8(input logic [7:0] l, input logic [7:0] r,
                                       input int unsigned j, input int unsigned w);
    return 8'((l * (w - j) + r * j) / w);
  endfunction

  function automatic blend_t blend_pixel(input pixel_t p, input logic [7:0] w_reg);
    int unsigned w;
    int unsigned j;
    blend_t      r;
    w = (w_reg == 8'd0) ? 1 : w_reg;
    j = p.seam_column;
    if (j >= w) j = w - 1;
    if ({p.left_red, p.left_green, p.left_blue} == 24'd0) begin
      r = '{src: tisfb_pkg::SRC_RIGHT, blue: p.right_blue, green: p.right_green,
            red: p.right_red};
    end else if ({p.right_red, p.right_green, p.right_blue} == 24'd0) begin
      r = '{src: tisfb_pkg::SRC_LEFT, blue: p.left_blue, green: p.left_green,
            red: p.left_red};
    end else begin
      r.src   = tisfb_pkg::SRC_RAMP;
      r.red   = ramp8(p.left_red, p.right_red, j, w);
      r.green = ramp8(p.left_green, p.right_green, j, w);
      r.blue  = ramp8(p.left_blue, p.right_blue, j, w);
    end
    return r;
  endfunction

  function automatic pixel_t pix(input logic [7:0] c, input logic [7:0] lr,
                                 input logic [7:0] lg, input logic [7:0] lb,
                                 input logic [7:0] rr, input logic [7:0] rg,
                                 input logic [7:0] rb);
    return '{right_blue: rb, right_green: rg, right_red: rr, left_blue: lb,
             left_green: lg, left_red: lr, seam_column: c};
  endfunction

  function automatic row_t prow(input pixel_t p);
    return '{is_cfg: 1'b0, width: 8'd0, pix: p, typed: 1'b0, want: '0};
  endfunction

  function automatic row_t trow(input pixel_t p, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input tisfb_pkg::src_t s);
    return '{is_cfg: 1'b0, width: 8'd0, pix: p, typed: 1'b1,
             want: '{src: s, blue: b, green: g, red: r}};
  endfunction

  function automatic row_t crow(input logic [7:0] w);
    return '{is_cfg: 1'b1, width: w, pix: '0, typed: 1'b0, want: '0};
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input pixel_t p, input logic typed, input blend_t w_exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    cur_typed <= typed;
    cur_want  <= w_exp;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_width(input logic [7:0] w);
    in_tvalid <= 1'b0;
    while (blend_q.size() != 0) @(negedge clk);
    repeat (tisfb_pkg::PIPE_DEPTH) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // scoreboard: expectations on input transactions, checks on output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (cur_typed) blend_q.push_back(cur_want);
        else blend_q.push_back(blend_pixel(in_tdata, seam_width_mdl));
      end
      if (out_tvalid && out_tready) begin
        got = '{src: tisfb_pkg::src_t'(out_tuser), blue: out_tdata[23:16],
                green: out_tdata[15:8], red: out_tdata[7:0]};
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = blend_q.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("weight_source", want.src, got.src);
        end
      end
      if (cfg_valid && cfg_ready) seam_width_mdl = cfg_data;
    end
  end

  initial begin
    pixel_t      p;
    logic [63:0] rnd;
    logic [7:0]  w;
    int unsigned wmax;
    int unsigned kind;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 8'd0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cur_typed = 1'b0;
    cur_want  = '0;

    // seam width is at its reset value for the first rows
    dir_tab.push_back(trow(pix(0, 200, 100, 50, 10, 20, 30), 200, 100, 50,
                           tisfb_pkg::SRC_RAMP));
    dir_tab.push_back(trow(pix(5, 0, 0, 0, 1, 2, 3), 1, 2, 3, tisfb_pkg::SRC_RIGHT));
    dir_tab.push_back(trow(pix(5, 255, 255, 255, 0, 0, 0), 255, 255, 255,
                           tisfb_pkg::SRC_LEFT));
    dir_tab.push_back(trow(pix(255, 0, 0, 0, 0, 0, 0), 0, 0, 0, tisfb_pkg::SRC_RIGHT));
    dir_tab.push_back(trow(pix(16, 255, 255, 255, 255, 255, 255), 255, 255, 255,
                           tisfb_pkg::SRC_RAMP));
    dir_tab.push_back(prow(pix(31, 255, 0, 128, 1, 254, 7)));
    dir_tab.push_back(prow(pix(32, 10, 200, 30, 250, 5, 90)));
    dir_tab.push_back(prow(pix(255, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55)));
    dir_tab.push_back(prow(pix(8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA)));
    dir_tab.push_back(prow(pix(8'hAA, 1, 0, 0, 0, 0, 1)));
    dir_tab.push_back(crow(8'd1));
    dir_tab.push_back(trow(pix(0, 9, 8, 7, 6, 5, 4), 9, 8, 7, tisfb_pkg::SRC_RAMP));
    dir_tab.push_back(trow(pix(255, 9, 8, 7, 6, 5, 4), 9, 8, 7, tisfb_pkg::SRC_RAMP));
    dir_tab.push_back(crow(8'd255));
    dir_tab.push_back(prow(pix(254, 255, 0, 0, 0, 255, 1)));
    dir_tab.push_back(prow(pix(255, 3, 3, 3, 250, 250, 250)));
    dir_tab.push_back(prow(pix(128, 100, 50, 25, 25, 50, 100)));
    // zero width behaves as one: left pixel wins the ramp
    dir_tab.push_back(crow(8'd0));
    dir_tab.push_back(trow(pix(200, 1, 2, 3, 4, 5, 6), 1, 2, 3, tisfb_pkg::SRC_RAMP));
    dir_tab.push_back(trow(pix(0, 0, 0, 0, 0, 0, 0), 0, 0, 0, tisfb_pkg::SRC_RIGHT));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_width(dir_tab[i].width);
      else send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 27 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        if (blk == 0) w = 8'd255;
        else if (blk == 1) w = 8'd1;
        else if (blk == 2 && phase == 0) w = 8'd0;
        else w = 8'($urandom_range(2, 254));
        write_width(w);
        wmax = (w == 8'd0) ? 1 : w;
        for (int k = 0; k < 50; k++) begin
          rnd = {$urandom, $urandom};
          p = rnd[55:0];
          kind = $urandom_range(0, 19);
          if (kind < 2) {p.left_red, p.left_green, p.left_blue} = '0;
          else if (kind < 4) {p.right_red, p.right_green, p.right_blue} = '0;
          else if (kind == 4) begin
            {p.left_red, p.left_green, p.left_blue} = '0;
            {p.right_red, p.right_green, p.right_blue} = '0;
          end
          if ($urandom_range(0, 3) != 0) p.seam_column = 8'($urandom_range(0, wmax - 1));
          send_pixel(p, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk);
    repeat (2 * tisfb_pkg::PIPE_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
